### design/combined_lcg_shuffle_rng_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the combined LCG shuffle generator
// Immediate-consequence and next-cycle checks, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef COMBINED_LCG_SHUFFLE_RNG_UNIT_ASSERT_SVH
`define COMBINED_LCG_SHUFFLE_RNG_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Consequence must hold in the same cycle as the antecedent.
`define CLSR_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clsr assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define CLSR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clsr assertion failed");

`else

`define CLSR_ASSERT_SAME(name, clk, rst, ante, cons)
`define CLSR_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

### design/clsr_pkg.sv
// ----------------------------------------------------------------------------
// clsr_pkg
// Constants and shared types of the combined LCG generator with shuffle table.
// ----------------------------------------------------------------------------
package clsr_pkg;

   // Width of every generator value and deviate.
   localparam int VAL_W = 31;

   // Moduli and multipliers of the two generators.
   localparam logic [VAL_W-1:0] MOD_ONE = 31'd2147483563;
   localparam logic [VAL_W-1:0] MOD_TWO = 31'd2147483399;
   localparam logic [15:0]      MUL_ONE = 16'd40014;
   localparam logic [15:0]      MUL_TWO = 16'd40692;

   // 2^31 minus each modulus, used to fold the high part of a product.
   localparam logic [7:0] FOLD_ONE = 8'd85;
   localparam logic [7:0] FOLD_TWO = 8'd249;

   // Largest deviate, and the reset value of the second generator.
   localparam logic [VAL_W-1:0] TOP_VAL     = 31'd2147483562;
   localparam logic [VAL_W-1:0] SECOND_INIT = 31'd123456789;

   // Steps of the first generator run before the table starts filling.
   localparam int WARMUP_STEPS = 8;

   // Which generator an operation belongs to.
   typedef enum logic {
      GEN_ONE,
      GEN_TWO
   } gen_sel_type;

   // Request to the shared modular multiplier.
   typedef struct packed {
      logic        start;
      gen_sel_type sel;
   } mm_ctl_type;

   // Completion status from the shared modular multiplier.
   typedef struct packed {
      logic        done;
      gen_sel_type sel;
   } mm_stat_type;

endpackage

### design/clsr_mulmod.sv
// ----------------------------------------------------------------------------
// clsr_mulmod
// Shared three-stage unit computing (a * x) mod m for either generator.
// ----------------------------------------------------------------------------
`include "combined_lcg_shuffle_rng_unit_assert.svh"

module clsr_mulmod
   import clsr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  mm_ctl_type       mm_ctl,
   input  logic [VAL_W-1:0] operand,
   output mm_stat_type      mm_stat,
   output logic [VAL_W-1:0] result
);

   localparam int PROD_W = VAL_W + 16;

   logic              v1_ff, v1_in;
   logic              v2_ff, v2_in;
   logic              v3_ff, v3_in;
   gen_sel_type       sel1_ff, sel2_ff, sel3_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [VAL_W:0]    fold_ff, fold_in;
   logic [VAL_W-1:0]  res_ff, res_in;
   logic [15:0]       mult;
   logic [7:0]        fold_c;
   logic [23:0]       hi_fold;
   logic [VAL_W-1:0]  mod3;

   // Stage one: multiply by the generator's constant.
   always_comb begin
      mult    = (mm_ctl.sel == GEN_ONE) ? MUL_ONE : MUL_TWO;
      prod_in = PROD_W'(operand) * PROD_W'(mult);
      v1_in   = mm_ctl.start;
   end

   // Stage two: fold the bits above 2^31 back in, since 2^31 = m + c.
   always_comb begin
      fold_c  = (sel1_ff == GEN_ONE) ? FOLD_ONE : FOLD_TWO;
      hi_fold = 24'(prod_ff[PROD_W-1:VAL_W]) * 24'(fold_c);
      fold_in = (VAL_W+1)'(prod_ff[VAL_W-1:0]) + (VAL_W+1)'(hi_fold);
      v2_in   = v1_ff;
   end

   // Stage three: the folded value is below twice the modulus, so one
   // conditional subtraction finishes the reduction.
   always_comb begin
      mod3 = (sel2_ff == GEN_ONE) ? MOD_ONE : MOD_TWO;
      if (fold_ff >= (VAL_W+1)'(mod3)) begin
         res_in = VAL_W'(fold_ff - (VAL_W+1)'(mod3));
      end else begin
         res_in = fold_ff[VAL_W-1:0];
      end
      v3_in = v2_ff;
   end

   // Stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      sel1_ff <= mm_ctl.sel;
      sel2_ff <= sel1_ff;
      sel3_ff <= sel2_ff;
      prod_ff <= prod_in;
      fold_ff <= fold_in;
      res_ff  <= res_in;
   end

   assign mm_stat.done = v3_ff;
   assign mm_stat.sel  = sel3_ff;
   assign result       = res_ff;

   // A finished result is always fully reduced.
   `CLSR_ASSERT_SAME(a_result_reduced, clock, reset, v3_ff,
      ((sel3_ff == GEN_ONE) ? (res_ff < MOD_ONE) : (res_ff < MOD_TWO)))

endmodule

### design/clsr_slot_div.sv
// ----------------------------------------------------------------------------
// clsr_slot_div
// Division of the previous deviate by the slot width, giving the shuffle
// table slot. A reciprocal multiply gives an estimate that is exact or one
// short, and one compare against the next multiple of the slot width settles
// it. The estimate is registered first, then the settled slot.
// ----------------------------------------------------------------------------
module clsr_slot_div
   import clsr_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [VAL_W-1:0]               dividend,
   output logic                           busy,
   output logic [$clog2(TABLE_DEPTH)-1:0] slot
);

   localparam int Q_W       = $clog2(TABLE_DEPTH);
   localparam int QX_W      = Q_W + 1;
   localparam int RCP_SHIFT = 37;
   localparam int RCP_W     = 14;
   localparam int EST_W     = VAL_W + RCP_W;
   localparam int THR_W     = VAL_W + QX_W;
   localparam longint unsigned SLOT_DIV_L =
      64'd1 + 64'(TOP_VAL) / 64'(TABLE_DEPTH);
   localparam longint unsigned RCP_L = (64'd1 << RCP_SHIFT) / SLOT_DIV_L;
   localparam logic [VAL_W-1:0] SLOT_DIV = VAL_W'(SLOT_DIV_L);
   localparam logic [RCP_W-1:0] RCP      = RCP_W'(RCP_L);

   logic             v1_ff, v1_in;
   logic [VAL_W-1:0] num_ff, num_in;
   logic [QX_W-1:0]  est_ff, est_in;
   logic [QX_W-1:0]  quo_ff, quo_in;
   logic [EST_W-1:0] est_prod;
   logic [THR_W-1:0] thr;

   // Stage one: estimate the quotient with the truncated reciprocal. The
   // estimate never exceeds the true quotient and is at most one below it.
   always_comb begin
      v1_in    = start;
      est_prod = EST_W'(dividend) * EST_W'(RCP);
      num_in   = num_ff;
      est_in   = est_ff;
      if (start) begin
         num_in = dividend;
         est_in = est_prod[RCP_SHIFT +: QX_W];
      end
   end

   // Stage two: step the estimate up when the dividend reaches the next
   // multiple of the slot width.
   always_comb begin
      thr    = (THR_W'(est_ff) + THR_W'(1)) * THR_W'(SLOT_DIV);
      quo_in = quo_ff;
      if (v1_ff) begin
         if (THR_W'(num_ff) >= thr) begin
            quo_in = est_ff + 1'b1;
         end else begin
            quo_in = est_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      est_ff <= est_in;
      quo_ff <= quo_in;
   end

   assign busy = v1_ff;

   // Guard: clamp to the last slot should the quotient ever reach the depth.
   assign slot = (quo_ff >= QX_W'(TABLE_DEPTH)) ?
                 Q_W'(TABLE_DEPTH - 1) : quo_ff[Q_W-1:0];

endmodule

### design/combined_lcg_shuffle_rng_unit.sv
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_unit
// Combined two-generator LCG with a Bays-Durham shuffle table. Each request
// beat on req_ returns one deviate beat on rsp_, 1..2147483562; dividing it
// by 2147483563 gives a uniform fraction inside (0,1).
// csr_wr_en writes the seed register (reset 1); it only takes effect at the
// next seeding. Seeding happens on the first request after reset, or when
// req_reseed is set, and runs TABLE_DEPTH+8 steps of the first generator.
// A plain draw makes two passes through the shared three-stage modular
// multiplier, one per generator, then a table read and the write-back; a
// new request is taken only after that. Seeding runs one pass per step.
// req_stall is high while an item is in work. A finished deviate waits in
// the output register while rsp_stall is high; the next request is still
// accepted and only its final write-back waits for the register to free.
// Reset is synchronous: the shuffle table is not cleared, as it is always
// filled by seeding before it is read.
// ----------------------------------------------------------------------------
`include "combined_lcg_shuffle_rng_unit_assert.svh"

module combined_lcg_shuffle_rng_unit
   import clsr_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_reseed,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [VAL_W-1:0] rsp_deviate,
   input  logic             csr_wr_en,
   input  logic [VAL_W-1:0] csr_wr_data
);

   localparam int ADDR_W     = $clog2(TABLE_DEPTH);
   localparam int SEED_STEPS = TABLE_DEPTH + WARMUP_STEPS;
   localparam int CNT_W      = $clog2(SEED_STEPS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_ISSUE,
      ST_SEED_WAIT,
      ST_DRAW_ONE,
      ST_WAIT_ONE,
      ST_DRAW_TWO,
      ST_WAIT_TWO,
      ST_READ,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [VAL_W-1:0] seed_value_ff, seed_value_in;
   logic [VAL_W-1:0] first_ff, first_in;
   logic [VAL_W-1:0] second_ff, second_in;
   logic [VAL_W-1:0] last_ff, last_in;
   logic             seed_pending_ff, seed_pending_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_deviate_ff, rsp_deviate_in;

   logic [VAL_W-1:0]  shuffle_mem [TABLE_DEPTH];
   logic [VAL_W-1:0]  rd_data_ff;
   logic              tbl_we;
   logic [ADDR_W-1:0] tbl_addr;
   logic [VAL_W-1:0]  tbl_wdata;

   mm_ctl_type        mm_ctl;
   mm_stat_type       mm_stat;
   logic [VAL_W-1:0]  mm_operand;
   logic [VAL_W-1:0]  mm_result;
   logic              div_start;
   logic              div_busy;
   logic [ADDR_W-1:0] div_slot;

   logic             accept;
   logic [VAL_W-1:0] seed_eff;
   logic [VAL_W:0]   diff;
   logic [VAL_W-1:0] deviate;

   // Shared modular multiplier.
   clsr_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .mm_ctl  (mm_ctl),
      .operand (mm_operand),
      .mm_stat (mm_stat),
      .result  (mm_result)
   );

   // Slot divider, runs alongside the first multiply of a draw.
   clsr_slot_div #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_slot_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (last_ff),
      .busy     (div_busy),
      .slot     (div_slot)
   );

   assign accept   = req_valid && !req_stall;
   assign seed_eff = (seed_value_ff == '0) ? VAL_W'(1) : seed_value_ff;

   // Deviate: slot value minus second generator, wrapped into 1..TOP_VAL.
   always_comb begin
      diff = {1'b0, rd_data_ff} - {1'b0, second_ff};
      if (diff[VAL_W] || (diff == '0)) begin
         deviate = diff[VAL_W-1:0] + TOP_VAL;
      end else begin
         deviate = diff[VAL_W-1:0];
      end
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in        = state_ff;
      seed_value_in   = seed_value_ff;
      first_in        = first_ff;
      second_in       = second_ff;
      last_in         = last_ff;
      seed_pending_in = seed_pending_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_deviate_in  = rsp_deviate_ff;
      mm_ctl.start    = 1'b0;
      mm_ctl.sel      = GEN_ONE;
      mm_operand      = first_ff;
      div_start       = 1'b0;
      tbl_we          = 1'b0;
      tbl_addr        = div_slot;
      tbl_wdata       = first_ff;

      if (csr_wr_en) begin
         seed_value_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (seed_pending_ff || req_reseed) begin
                  first_in  = seed_eff;
                  second_in = seed_eff;
                  cnt_in    = CNT_W'(SEED_STEPS - 1);
                  state_in  = ST_SEED_ISSUE;
               end else begin
                  state_in = ST_DRAW_ONE;
               end
            end
         end
         ST_SEED_ISSUE: begin
            mm_ctl.start = 1'b1;
            state_in     = ST_SEED_WAIT;
         end
         ST_SEED_WAIT: begin
            if (mm_stat.done) begin
               first_in = mm_result;
               if (cnt_ff < CNT_W'(TABLE_DEPTH)) begin
                  tbl_we    = 1'b1;
                  tbl_addr  = cnt_ff[ADDR_W-1:0];
                  tbl_wdata = mm_result;
               end
               if (cnt_ff == '0) begin
                  last_in         = mm_result;
                  seed_pending_in = 1'b0;
                  state_in        = ST_DRAW_ONE;
               end else begin
                  cnt_in   = cnt_ff - 1'b1;
                  state_in = ST_SEED_ISSUE;
               end
            end
         end
         ST_DRAW_ONE: begin
            mm_ctl.start = 1'b1;
            div_start    = 1'b1;
            state_in     = ST_WAIT_ONE;
         end
         ST_WAIT_ONE: begin
            if (mm_stat.done) begin
               first_in = mm_result;
               state_in = ST_DRAW_TWO;
            end
         end
         ST_DRAW_TWO: begin
            mm_ctl.start = 1'b1;
            mm_ctl.sel   = GEN_TWO;
            mm_operand   = second_ff;
            state_in     = ST_WAIT_TWO;
         end
         ST_WAIT_TWO: begin
            if (mm_stat.done) begin
               second_in = mm_result;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // Write back only once the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_deviate_in = deviate;
               last_in        = deviate;
               tbl_we         = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         seed_value_ff   <= VAL_W'(1);
         first_ff        <= '0;
         second_ff       <= SECOND_INIT;
         last_ff         <= '0;
         seed_pending_ff <= 1'b1;
         cnt_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         seed_value_ff   <= seed_value_in;
         first_ff        <= first_in;
         second_ff       <= second_in;
         last_ff         <= last_in;
         seed_pending_ff <= seed_pending_in;
         cnt_ff          <= cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_deviate_ff <= rsp_deviate_in;
   end

   // Shuffle table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         shuffle_mem[tbl_addr] <= tbl_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_data_ff <= shuffle_mem[div_slot];
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_deviate = rsp_deviate_ff;

   // The slot must be settled before the table is read.
   `CLSR_ASSERT_SAME(a_slot_ready, clock, reset, (state_ff == ST_READ), !div_busy)
   // The second multiply's result must belong to the second generator.
   `CLSR_ASSERT_SAME(a_second_tag, clock, reset,
      ((state_ff == ST_WAIT_TWO) && mm_stat.done), (mm_stat.sel == GEN_TWO))
   // A draw never starts with seeding still owed.
   `CLSR_ASSERT_SAME(a_seeded, clock, reset, (state_ff == ST_DRAW_ONE), !seed_pending_ff)
   // Every delivered deviate lies in its range.
   `CLSR_ASSERT_SAME(a_range, clock, reset, rsp_valid_ff,
      ((rsp_deviate_ff != '0) && (rsp_deviate_ff <= TOP_VAL)))

endmodule
